// ----- design/min_window_all_labels_assert.svh -----
// Assertion macros for the minimum covering window block.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef MIN_WINDOW_ALL_LABELS_ASSERT_SVH
`define MIN_WINDOW_ALL_LABELS_ASSERT_SVH

// Check a property at every clock edge out of reset.
`define MWAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define MWAL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ----- design/mwal_pkg.sv -----
// Shared types and constants for the minimum covering window block.
// No dependencies; used by the interfaces, the position store and the top level.
package mwal_pkg;

  localparam int MAX_WORDS = 64;
  localparam int POS_W     = 30;
  localparam int WORD_W    = $clog2(MAX_WORDS);
  localparam int LEN_W     = 31;
  localparam int CNT_W     = $clog2(MAX_WORDS + 1);
  localparam int CFG_W     = 7;

  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [CFG_W-1:0]  cfg_t;

  localparam pos_t POS_MAX    = '1;
  localparam cnt_t WORDS_LAST = CNT_W'(MAX_WORDS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_UPDATE,
    S_SCAN,
    S_MEASURE,
    S_DONE
  } state_t;

  // Request from the sequencer to the position store.
  typedef struct packed {
    logic  we;
    word_t waddr;
    pos_t  wdata;
    word_t raddr;
  } mem_req_t;

endpackage

// ----- design/mwal_if.sv -----
// Valid/ready channel interfaces for the minimum covering window block.
// Depends on mwal_pkg for the payload types.
interface mwal_in_if;
  logic                 valid;
  logic                 ready;
  mwal_pkg::pos_t       position;
  mwal_pkg::word_t      word;
  logic                 last;

  modport source (output valid, output position, output word, output last, input ready);
  modport sink   (input valid, input position, input word, input last, output ready);
endinterface

interface mwal_out_if;
  logic                 valid;
  logic                 ready;
  mwal_pkg::len_t       best_length;
  logic                 found;
  logic                 final_res;

  modport source (output valid, output best_length, output found, output final_res,
                  input ready);
  modport sink   (input valid, input best_length, input found, input final_res,
                  output ready);
endinterface

interface mwal_cfg_if;
  logic                 valid;
  logic                 ready;
  mwal_pkg::cfg_t       words_in_use;

  modport source (output valid, output words_in_use, input ready);
  modport sink   (input valid, input words_in_use, output ready);
endinterface

// ----- design/mwal_pos_store.sv -----
// Last-seen position store: one write port, one read port with registered data.
// Depends on mwal_pkg for the request struct and widths.
module mwal_pos_store (
  input  logic                clk,
  input  mwal_pkg::mem_req_t  req,
  output mwal_pkg::pos_t      rd_data
);

  mwal_pkg::pos_t mem [mwal_pkg::MAX_WORDS];
  mwal_pkg::pos_t rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

// ----- design/min_window_all_labels.sv -----
// Top level of the minimum covering window block: sequencer, coverage state and
// output register. Depends on mwal_pkg, the channel interfaces and mwal_pos_store.
//
// Usage:
//   in_if  : occurrence words (position, word, last), accepted on valid & ready.
//   out_if : one result word per input word (best_length, found, final_res).
//   cfg_if : writes words_in_use (0 acts as 1, above 64 saturates); a write
//            also clears the set state. Write only while the block is idle.
// Sequencing:
//   An accepted word passes S_LOOKUP and S_UPDATE, then goes straight to S_DONE
//   when its label is not in use, through S_MEASURE when the left edge holds,
//   and through S_SCAN and S_MEASURE when the leftmost label reappears (or on the
//   first label of a set): the left edge is then rebuilt by a minimum scan over
//   the 64 stored positions, one entry per cycle through the single read port of
//   the position store. A new word is taken only once the result is registered,
//   so no word is taken before the block is through with the last one.
// Reset (rst_n low, synchronous) clears all set state and sets words_in_use to 1.
// The result sits in an output register; the block accepts the next word while
// it waits, and holds its next result until out_if.ready frees the register.
`include "min_window_all_labels_assert.svh"

module min_window_all_labels (
  input  logic        clk,
  input  logic        rst_n,
  mwal_in_if.sink     in_if,
  mwal_out_if.source  out_if,
  mwal_cfg_if.sink    cfg_if
);

  mwal_pkg::state_t state_r, state_nxt;

  mwal_pkg::cfg_t  words_in_use_r, words_in_use_nxt;
  mwal_pkg::pos_t  pos_r, pos_nxt;
  mwal_pkg::word_t word_r, word_nxt;
  logic            last_r, last_nxt;

  logic [mwal_pkg::MAX_WORDS-1:0] seen_mark_r, seen_mark_nxt;
  mwal_pkg::cnt_t  labels_found_r, labels_found_nxt;
  mwal_pkg::pos_t  left_edge_r, left_edge_nxt;
  mwal_pkg::len_t  best_r, best_nxt;
  logic            best_valid_r, best_valid_nxt;

  mwal_pkg::cnt_t  scan_cnt_r, scan_cnt_nxt;
  mwal_pkg::pos_t  min_r, min_nxt;
  logic            rd_valid_r, rd_valid_nxt;
  logic            rd_mark_r, rd_mark_nxt;

  logic            out_valid_r, out_valid_nxt;
  mwal_pkg::len_t  out_len_r, out_len_nxt;
  logic            out_found_r, out_found_nxt;
  logic            out_final_r, out_final_nxt;

  mwal_pkg::mem_req_t mem_req;
  mwal_pkg::pos_t     rd_data;

  mwal_pkg::cnt_t  n_eff;
  logic            in_use;
  logic            was_seen;
  logic            need_scan;
  logic            scan_issue;
  logic            covered;
  mwal_pkg::len_t  win_len;
  logic            out_free;
  logic            in_acc;
  logic            cfg_acc;

  mwal_pos_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign in_if.ready   = (state_r == mwal_pkg::S_IDLE);
  assign cfg_if.ready  = (state_r == mwal_pkg::S_IDLE);
  assign in_acc        = in_if.valid & in_if.ready;
  assign cfg_acc       = cfg_if.valid & cfg_if.ready;

  assign out_if.valid       = out_valid_r;
  assign out_if.best_length = out_len_r;
  assign out_if.found       = out_found_r;
  assign out_if.final_res   = out_final_r;
  assign out_free           = !out_valid_r || out_if.ready;

  // Effective label count: zero acts as one, saturate at the table depth.
  always_comb begin
    if (words_in_use_r == '0) begin
      n_eff = mwal_pkg::CNT_W'(1);
    end else if (mwal_pkg::CNT_W'(words_in_use_r) > mwal_pkg::WORDS_LAST) begin
      n_eff = mwal_pkg::WORDS_LAST;
    end else begin
      n_eff = mwal_pkg::CNT_W'(words_in_use_r);
    end
  end

  assign in_use     = mwal_pkg::CNT_W'(word_r) < n_eff;
  assign was_seen   = seen_mark_r[word_r];
  assign need_scan  = (labels_found_r == '0) || (was_seen && (rd_data == left_edge_r));
  assign scan_issue = scan_cnt_r < mwal_pkg::WORDS_LAST;
  assign covered    = (labels_found_r == n_eff) && (pos_r >= left_edge_r);
  assign win_len    = mwal_pkg::LEN_W'(pos_r - left_edge_r) + mwal_pkg::LEN_W'(1);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mwal_pkg::S_IDLE: begin
        if (in_acc) state_nxt = mwal_pkg::S_LOOKUP;
      end
      mwal_pkg::S_LOOKUP: state_nxt = mwal_pkg::S_UPDATE;
      mwal_pkg::S_UPDATE: begin
        if (!in_use) begin
          state_nxt = mwal_pkg::S_DONE;
        end else if (need_scan) begin
          state_nxt = mwal_pkg::S_SCAN;
        end else begin
          state_nxt = mwal_pkg::S_MEASURE;
        end
      end
      mwal_pkg::S_SCAN: begin
        if (!scan_issue) state_nxt = mwal_pkg::S_MEASURE;
      end
      mwal_pkg::S_MEASURE: state_nxt = mwal_pkg::S_DONE;
      mwal_pkg::S_DONE: begin
        if (out_free) state_nxt = mwal_pkg::S_IDLE;
      end
      default: state_nxt = mwal_pkg::S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    words_in_use_nxt = words_in_use_r;
    pos_nxt          = pos_r;
    word_nxt         = word_r;
    last_nxt         = last_r;
    seen_mark_nxt    = seen_mark_r;
    labels_found_nxt = labels_found_r;
    left_edge_nxt    = left_edge_r;
    best_nxt         = best_r;
    best_valid_nxt   = best_valid_r;
    scan_cnt_nxt     = scan_cnt_r;
    min_nxt          = min_r;
    rd_valid_nxt     = 1'b0;
    rd_mark_nxt      = seen_mark_r[scan_cnt_r[mwal_pkg::WORD_W-1:0]];
    out_valid_nxt    = out_valid_r && !out_if.ready;
    out_len_nxt      = out_len_r;
    out_found_nxt    = out_found_r;
    out_final_nxt    = out_final_r;

    mem_req.we    = 1'b0;
    mem_req.waddr = word_r;
    mem_req.wdata = pos_r;
    mem_req.raddr = scan_cnt_r[mwal_pkg::WORD_W-1:0];

    case (state_r)
      mwal_pkg::S_IDLE: begin
        if (in_acc) begin
          pos_nxt  = in_if.position;
          word_nxt = in_if.word;
          last_nxt = in_if.last;
        end
        if (cfg_acc) begin
          words_in_use_nxt = cfg_if.words_in_use;
          seen_mark_nxt    = '0;
          labels_found_nxt = '0;
          left_edge_nxt    = '0;
          best_nxt         = '0;
          best_valid_nxt   = 1'b0;
        end
      end
      mwal_pkg::S_LOOKUP: begin
        mem_req.raddr = word_r;
      end
      mwal_pkg::S_UPDATE: begin
        if (in_use) begin
          mem_req.we            = 1'b1;
          seen_mark_nxt[word_r] = 1'b1;
          if (!was_seen) labels_found_nxt = labels_found_r + mwal_pkg::CNT_W'(1);
          scan_cnt_nxt = '0;
          min_nxt      = mwal_pkg::POS_MAX;
        end
      end
      mwal_pkg::S_SCAN: begin
        // Fold the entry read last cycle into the running minimum.
        if (rd_valid_r && rd_mark_r && (rd_data < min_r)) min_nxt = rd_data;
        if (scan_issue) begin
          rd_valid_nxt = 1'b1;
          scan_cnt_nxt = scan_cnt_r + mwal_pkg::CNT_W'(1);
        end else begin
          left_edge_nxt = min_nxt;
        end
      end
      mwal_pkg::S_MEASURE: begin
        if (covered && (!best_valid_r || (win_len < best_r))) begin
          best_nxt       = win_len;
          best_valid_nxt = 1'b1;
        end
      end
      mwal_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_len_nxt   = best_valid_r ? best_r : '0;
          out_found_nxt = best_valid_r;
          out_final_nxt = last_r;
          // End of set: drop all coverage state.
          if (last_r) begin
            seen_mark_nxt    = '0;
            labels_found_nxt = '0;
            left_edge_nxt    = '0;
            best_nxt         = '0;
            best_valid_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mwal_pkg::S_IDLE;
      words_in_use_r <= mwal_pkg::CFG_W'(1);
      seen_mark_r    <= '0;
      labels_found_r <= '0;
      left_edge_r    <= '0;
      best_r         <= '0;
      best_valid_r   <= 1'b0;
      scan_cnt_r     <= '0;
      rd_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      words_in_use_r <= words_in_use_nxt;
      seen_mark_r    <= seen_mark_nxt;
      labels_found_r <= labels_found_nxt;
      left_edge_r    <= left_edge_nxt;
      best_r         <= best_nxt;
      best_valid_r   <= best_valid_nxt;
      scan_cnt_r     <= scan_cnt_nxt;
      rd_valid_r     <= rd_valid_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    word_r      <= word_nxt;
    last_r      <= last_nxt;
    min_r       <= min_nxt;
    rd_mark_r   <= rd_mark_nxt;
    out_len_r   <= out_len_nxt;
    out_found_r <= out_found_nxt;
    out_final_r <= out_final_nxt;
  end

  `MWAL_ASSERT(a_count_matches_marks, (labels_found_r == mwal_pkg::CNT_W'($countones(seen_mark_r))), "label count disagrees with seen marks")
  `MWAL_ASSERT(a_count_in_range, (labels_found_r <= n_eff), "label count above labels in use")
  `MWAL_ASSERT(a_best_zero_when_none, (best_valid_r || (best_r == '0)), "best length set without a window")
  `MWAL_ASSERT_NEXT(a_scan_edge_bound, ((state_r == mwal_pkg::S_SCAN) && !scan_issue), (left_edge_r <= pos_r), "rebuilt left edge beyond current position")
  `MWAL_ASSERT_NEXT(a_result_after_done, ((state_r == mwal_pkg::S_DONE) && out_free), out_valid_r, "result not registered after completion")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for min_window_all_labels: drives occurrence words, tracks
// the shortest covering window in a local model and checks every result word.
// Depends on mwal_pkg, the channel interfaces in mwal_if.sv and the design top.
module tb_top;

  localparam int IDLE_LIMIT  = 5000;
  localparam int SETTLE_CYC  = 80;
  localparam int HOLD_CYC    = 400;
  localparam int PHASE_ITEMS = 230;
  localparam int SEG_ITEMS   = 70;
  localparam int MAX_PRINTS  = 50;

  typedef struct packed {
    mwal_pkg::len_t best_length;
    logic found;
    logic final_res;
  } window_res_t;

  logic clk;
  logic rst_n;

  mwal_in_if  in_ch();
  mwal_out_if out_ch();
  mwal_cfg_if cfg_ch();

  min_window_all_labels u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch),
    .cfg_if (cfg_ch)
  );

  // Local copy of the coverage state
  mwal_pkg::pos_t label_pos  [mwal_pkg::MAX_WORDS];
  logic           label_seen [mwal_pkg::MAX_WORDS];
  int             labels_hit;
  mwal_pkg::pos_t window_left;
  mwal_pkg::len_t shortest_len;
  logic           shortest_ok;
  mwal_pkg::cfg_t words_reg;

  window_res_t expected_results[$];

  int   errors = 0;
  int   words_sent = 0;
  int   results_checked = 0;
  int   cfg_writes = 0;
  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   hold_request = 0;
  int   hold_left = 0;
  int   idle_cycles = 0;
  logic in_offered = 1'b0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int active_labels();
    int n;
    n = words_reg;
    if (n == 0) n = 1;
    if (n > mwal_pkg::MAX_WORDS) n = mwal_pkg::MAX_WORDS;
    return n;
  endfunction

  function automatic void clear_window_state();
    int i;
    for (i = 0; i < mwal_pkg::MAX_WORDS; i++) label_seen[i] = 1'b0;
    labels_hit   = 0;
    window_left  = '0;
    shortest_len = '0;
    shortest_ok  = 1'b0;
  endfunction

  function automatic void reset_model();
    int i;
    for (i = 0; i < mwal_pkg::MAX_WORDS; i++) label_pos[i] = '0;
    words_reg = mwal_pkg::cfg_t'(1);
    clear_window_state();
  endfunction

  function automatic window_res_t predict_window(mwal_pkg::pos_t p, mwal_pkg::word_t w,
                                                 logic l);
    logic           was_seen;
    logic           first_word;
    mwal_pkg::pos_t old_pos;
    mwal_pkg::pos_t edge_min;
    mwal_pkg::len_t len;
    window_res_t    r;
    int             i;
    if (int'(w) < active_labels()) begin
      was_seen   = label_seen[w];
      old_pos    = label_pos[w];
      first_word = (labels_hit == 0);
      if (!was_seen) begin
        label_seen[w] = 1'b1;
        labels_hit++;
      end
      label_pos[w] = p;
      // Rebuild the left edge on the first word of a set or when the leftmost label moves on
      if (first_word || (was_seen && old_pos == window_left)) begin
        edge_min = mwal_pkg::POS_MAX;
        for (i = 0; i < mwal_pkg::MAX_WORDS; i++) begin
          if (label_seen[i] && label_pos[i] < edge_min) edge_min = label_pos[i];
        end
        window_left = edge_min;
      end
      if (labels_hit == active_labels() && p >= window_left) begin
        len = {1'b0, mwal_pkg::pos_t'(p - window_left)} + mwal_pkg::len_t'(1);
        if (!shortest_ok || len < shortest_len) begin
          shortest_len = len;
          shortest_ok  = 1'b1;
        end
      end
    end
    r.best_length = shortest_ok ? shortest_len : '0;
    r.found       = shortest_ok;
    r.final_res   = l;
    if (l) clear_window_state();
    return r;
  endfunction

  task automatic send_word(input mwal_pkg::pos_t p, input mwal_pkg::word_t w, input logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      if (in_offered) begin
        in_ch.valid <= 1'b0;
        in_offered = 1'b0;
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.position <= p;
    in_ch.word     <= w;
    in_ch.last     <= l;
    in_offered = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_results.push_back(predict_window(p, w, l));
    words_sent++;
  endtask

  task automatic wait_drained();
    if (in_offered) begin
      in_ch.valid <= 1'b0;
      in_offered = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_words(input mwal_pkg::cfg_t v);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.words_in_use <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    words_reg = v;
    clear_window_state();
    cfg_writes++;
  endtask

  function automatic mwal_pkg::cfg_t pick_words_setting();
    int r;
    r = $urandom_range(99);
    if (r < 55) return mwal_pkg::cfg_t'($urandom_range(1, 6));
    if (r < 70) return mwal_pkg::cfg_t'($urandom_range(7, 20));
    if (r < 78) return mwal_pkg::cfg_t'(0);
    if (r < 86) return mwal_pkg::cfg_t'(mwal_pkg::MAX_WORDS);
    if (r < 92) return mwal_pkg::cfg_t'($urandom_range(65, 127));
    return mwal_pkg::cfg_t'($urandom_range(21, 63));
  endfunction

  // One set: ascending positions, mostly labels in use, a little noise
  task automatic send_random_set();
    int              n;
    int              set_len;
    int              step_max;
    int              offset;
    int              i;
    int              r;
    int unsigned     cur;
    int unsigned     top;
    mwal_pkg::word_t w;
    mwal_pkg::pos_t  p;
    n = active_labels();
    if ($urandom_range(9) < 7) set_len = $urandom_range(n, (3 * n + 2 > 160) ? 160 : 3 * n + 2);
    else set_len = $urandom_range(1, n + 2);
    step_max = ($urandom_range(1) == 1) ? 3 : (1 << 20);
    offset   = $urandom_range(63);
    top      = 32'(mwal_pkg::POS_MAX) - set_len * step_max - 1;
    case ($urandom_range(2))
      0: cur = 0;
      1: cur = top;
      default: cur = $urandom_range(top, 0);
    endcase
    for (i = 0; i < set_len; i++) begin
      r = $urandom_range(99);
      if (r < 50) w = mwal_pkg::word_t'((i + offset) % n);
      else if (r < 88) w = mwal_pkg::word_t'($urandom_range(n - 1));
      else w = mwal_pkg::word_t'($urandom);
      if (i > 0 && $urandom_range(99) < 4) begin
        p = mwal_pkg::pos_t'($urandom_range(cur, 0));
      end else begin
        if (i > 0) cur = cur + $urandom_range(1, step_max);
        p = mwal_pkg::pos_t'(cur);
      end
      send_word(p, w, i == set_len - 1);
    end
  endtask

  task automatic test_default_register();
    send_word(mwal_pkg::pos_t'(0), mwal_pkg::word_t'(0), 1'b0);
    send_word(mwal_pkg::pos_t'(7), mwal_pkg::word_t'(5), 1'b0);
    send_word(mwal_pkg::pos_t'(9), mwal_pkg::word_t'(0), 1'b1);
  endtask

  task automatic test_register_extremes();
    // zero acts as one label
    write_words(mwal_pkg::cfg_t'(0));
    send_word(mwal_pkg::pos_t'(3), mwal_pkg::word_t'(1), 1'b0);
    send_word(mwal_pkg::pos_t'(4), mwal_pkg::word_t'(0), 1'b1);
    // saturate to all labels
    write_words(mwal_pkg::cfg_t'(127));
    send_word(mwal_pkg::pos_t'(100), mwal_pkg::word_t'(63), 1'b0);
    send_word(mwal_pkg::pos_t'(101), mwal_pkg::word_t'(0), 1'b1);
  endtask

  task automatic test_window_rebuild();
    write_words(mwal_pkg::cfg_t'(3));
    send_word(mwal_pkg::pos_t'(10), mwal_pkg::word_t'(0), 1'b0);
    send_word(mwal_pkg::pos_t'(12), mwal_pkg::word_t'(1), 1'b0);
    send_word(mwal_pkg::pos_t'(13), mwal_pkg::word_t'(0), 1'b0);
    send_word(mwal_pkg::pos_t'(20), mwal_pkg::word_t'(2), 1'b0);
    send_word(mwal_pkg::pos_t'(21), mwal_pkg::word_t'(1), 1'b0);
    send_word(mwal_pkg::pos_t'(22), mwal_pkg::word_t'(0), 1'b1);
  endtask

  task automatic test_out_of_order();
    write_words(mwal_pkg::cfg_t'(2));
    send_word(mwal_pkg::pos_t'(100), mwal_pkg::word_t'(0), 1'b0);
    send_word(mwal_pkg::pos_t'(200), mwal_pkg::word_t'(1), 1'b0);
    // below the left edge: no measurement
    send_word(mwal_pkg::pos_t'(50), mwal_pkg::word_t'(1), 1'b0);
    send_word(mwal_pkg::pos_t'(30), mwal_pkg::word_t'(0), 1'b1);
  endtask

  task automatic test_position_extremes();
    send_word(mwal_pkg::pos_t'(0), mwal_pkg::word_t'(0), 1'b0);
    send_word(mwal_pkg::POS_MAX, mwal_pkg::word_t'(1), 1'b0);
    send_word(mwal_pkg::POS_MAX, mwal_pkg::word_t'(0), 1'b1);
  endtask

  task automatic test_random_phase(input int snd_pct, input int rcv_pct);
    int phase_start;
    int seg_start;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    phase_start = words_sent;
    while (words_sent - phase_start < PHASE_ITEMS) begin
      write_words(pick_words_setting());
      seg_start = words_sent;
      while (words_sent - seg_start < SEG_ITEMS) send_random_set();
    end
  endtask

  task automatic test_backpressure();
    int i;
    write_words(mwal_pkg::cfg_t'(4));
    // hold the result side while words keep coming
    hold_request = HOLD_CYC;
    for (i = 0; i < 3; i++) send_random_set();
    // pause the sender until every result is in, then resume
    wait_drained();
    send_random_set();
  endtask

  // Result side ready, with a long hold on request
  always @(posedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    window_res_t got;
    window_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.best_length, out_ch.found, out_ch.final_res};
      if (expected_results.size() == 0) begin
        if (errors < MAX_PRINTS)
          $display("%0t: unexpected result word: best_length %0d found %0b final_res %0b",
                   $time, got.best_length, got.found, got.final_res);
        errors++;
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (got !== want) begin
          if (errors < MAX_PRINTS)
            $display("%0t: expected best_length %0d found %0b final_res %0b, actual %0d %0b %0b",
                     $time, want.best_length, want.found, want.final_res,
                     got.best_length, got.found, got.final_res);
          errors++;
        end
      end
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.position      = '0;
    in_ch.word          = '0;
    in_ch.last          = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.words_in_use = '0;
    out_ch.ready        = 1'b0;
    send_idle_pct       = 12;
    recv_idle_pct       = 79;
    reset_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_register();
    test_register_extremes();
    test_window_rebuild();
    test_out_of_order();
    test_position_extremes();
    test_random_phase(12, 79);
    test_random_phase(79, 12);
    test_random_phase(0, 0);
    test_backpressure();

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk);
    if (expected_results.size() != 0) errors++;
    $display("Sent %0d occurrence words, checked %0d results, %0d register writes;",
             words_sent, results_checked, cfg_writes);
    $display("three idle profiles plus a long result-side hold, %0d errors.", errors);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ----- min_window_all_labels.f -----
+incdir+design
design/mwal_pkg.sv
design/mwal_if.sv
design/mwal_pos_store.sv
design/min_window_all_labels.sv
bench/tb_top.sv
